### hdl/hbs_pkg.sv
// Shared types and constants of the heightmap bilinear sampler.
package hbs_pkg;

  // Store geometry: 256 x 256 cells, split into four banks by column and row parity
  localparam int STORE_SIDE = 256;
  localparam int CELL_W     = 8;
  localparam int HEIGHT_W   = 16;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_AW    = 2 * (CELL_W - 1);

  // Largest map side the block serves, and the default fraction width of a point
  localparam int MAP_SIZE      = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int RAW_W   = 24;
  localparam int GAIN_W  = 24;
  localparam int SIZE_W  = 9;
  localparam int POINT_W = 16;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [SIZE_W-1:0] MAP_SIZE_RST    = SIZE_W'(256);
  localparam logic [GAIN_W-1:0] HEIGHT_GAIN_RST = GAIN_W'(65536);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_MAP_SIZE    = 1'b0,
    REG_HEIGHT_GAIN = 1'b1
  } reg_idx_t;

  // Control of the banked height store for one cycle
  typedef struct packed {
    logic                                rd;
    logic                                wr;
    logic [1:0]                          wr_bank;
    logic [BANK_AW-1:0]                  wr_addr;
    logic [HEIGHT_W-1:0]                 wr_data;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]   rd_addr;
  } store_ctrl_t;

endpackage

### hdl/hbs_if.sv
// Request and response channel interfaces of the heightmap bilinear sampler.
interface hbs_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  cell_x;
  logic [7:0]  cell_y;
  logic [15:0] cell_height;
  logic [15:0] point_x;
  logic [15:0] point_y;

  modport source (output valid, cmd, cell_x, cell_y, cell_height, point_x, point_y,
                  input ready);
  modport sink   (input valid, cmd, cell_x, cell_y, cell_height, point_x, point_y,
                  output ready);
endinterface

interface hbs_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] height_raw;
  logic [23:0] height_scaled;
  logic        outside_map;

  modport source (output valid, height_raw, height_scaled, outside_map, input ready);
  modport sink   (input valid, height_raw, height_scaled, outside_map, output ready);
endinterface

### hdl/hbs_store.sv
// Four-bank height store, one synchronous dual-port memory per parity pair.
module hbs_store
  import hbs_pkg::*;
(
  input  logic                                clk,
  input  store_ctrl_t                         ctrl,
  output logic [NUM_BANKS-1:0][HEIGHT_W-1:0]  rdata
);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [HEIGHT_W-1:0] mem [2**BANK_AW];

    always_ff @(posedge clk) begin
      if (ctrl.wr && (ctrl.wr_bank == 2'(b))) begin
        mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd) begin
        rdata[b] <= mem[ctrl.rd_addr[b]];
      end
    end
  end

endmodule

### hdl/heightmap_bilinear_sampler_core.sv
// Top level of the heightmap bilinear sampler: banked store, blend pipeline, APB registers.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------------
//   req     | in  | valid/ready          | cmd, cell_x, cell_y, cell_height, point_x/y
//   rsp     | out | valid/ready          | height_raw, height_scaled, outside_map
//   apb     | in  | psel/penable/pready  | paddr, pwdata, prdata (map_size, height_gain)
//
// One item per cycle while req.ready is high; the four cells of a sample come from four
// parity banks in one read. A sample result passes stages 1 to 4 and leaves from the
// stage 4 register; a write item is stored on acceptance, with no result. Synchronous reset
// clears the stage valid bits and sets the APB registers to reset values; the store holds
// no reset value. A stalled rsp fills the four stages one by one before req.ready drops.
module heightmap_bilinear_sampler_core
  import hbs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  hbs_req_if.sink            req,
  hbs_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int FW  = FRAC_BITS;
  localparam int RW  = HEIGHT_W + FW;
  localparam int CW  = RAW_W + FW;
  localparam int SHR = (FW >= 8) ? FW - 8 : 0;
  localparam int SHL = (FW < 8) ? 8 - FW : 0;
  localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};
  localparam logic [SIZE_W-1:0] SIDE_MAX =
    SIZE_W'((MAP_SIZE < STORE_SIDE) ? MAP_SIZE : STORE_SIDE);

  // ---------------- configuration registers ----------------
  logic [SIZE_W-1:0] map_size;
  logic [GAIN_W-1:0] height_gain;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size    <= MAP_SIZE_RST;
      height_gain <= HEIGHT_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAP_SIZE:    map_size    <= pwdata[SIZE_W-1:0];
        REG_HEIGHT_GAIN: height_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAP_SIZE:    prdata = DATA_W'(map_size);
      REG_HEIGHT_GAIN: prdata = DATA_W'(height_gain);
      default:         prdata = '0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic acc, acc_sample, acc_write;

  assign rdy4      = !v4 || rsp.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;

  assign acc        = req.valid && req.ready;
  assign acc_sample = acc && (req.cmd == CMD_SAMPLE);
  assign acc_write  = acc && (req.cmd == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= acc_sample;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------- point decode and bank addressing ----------------
  logic [SIZE_W-1:0]  side;
  logic [POINT_W:0]   xi, yi;
  logic [CELL_W-1:0]  x8, y8, nx8, ny8;
  logic [FW-1:0]      dx, dy;
  logic               outside;
  logic [NUM_BANKS-1:0][CELL_W-1:0] bank_col, bank_row;
  store_ctrl_t        sctrl;
  logic [NUM_BANKS-1:0][HEIGHT_W-1:0] rdata;

  always_comb begin
    if (map_size < SIZE_W'(2)) begin
      side = SIZE_W'(2);
    end else if (map_size > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = map_size;
    end
  end

  assign xi      = {1'b0, req.point_x} >> FW;
  assign yi      = {1'b0, req.point_y} >> FW;
  assign dx      = req.point_x[FW-1:0];
  assign dy      = req.point_y[FW-1:0];
  assign outside = (xi >= (POINT_W+1)'(side)) || (yi >= (POINT_W+1)'(side));
  assign x8      = xi[CELL_W-1:0];
  assign y8      = yi[CELL_W-1:0];
  // clamp the next column and row to the last cell of the map
  assign nx8 = (({1'b0, x8} + SIZE_W'(1)) < side) ? x8 + CELL_W'(1)
                                                  : CELL_W'(side - SIZE_W'(1));
  assign ny8 = (({1'b0, y8} + SIZE_W'(1)) < side) ? y8 + CELL_W'(1)
                                                  : CELL_W'(side - SIZE_W'(1));

  // bank b holds column parity b[0] and row parity b[1]
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_col[b] = (x8[0] == b[0]) ? x8 : nx8;
      bank_row[b] = (y8[0] == b[1]) ? y8 : ny8;
    end
  end

  always_comb begin
    sctrl.rd      = acc_sample;
    sctrl.wr      = acc_write;
    sctrl.wr_bank = {req.cell_y[0], req.cell_x[0]};
    sctrl.wr_addr = {req.cell_y[CELL_W-1:1], req.cell_x[CELL_W-1:1]};
    sctrl.wr_data = req.cell_height;
    for (int b = 0; b < NUM_BANKS; b++) begin
      sctrl.rd_addr[b] = {bank_row[b][CELL_W-1:1], bank_col[b][CELL_W-1:1]};
    end
  end

  hbs_store u_store (
    .clk   (clk),
    .ctrl  (sctrl),
    .rdata (rdata)
  );

  // ---------------- stage 1: bank data valid, blend along x ----------------
  logic          s1_outside, s1_xp, s1_nxp, s1_yp, s1_nyp;
  logic [FW-1:0] s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_outside <= outside;
      s1_dx      <= dx;
      s1_dy      <= dy;
      s1_xp      <= x8[0];
      s1_nxp     <= nx8[0];
      s1_yp      <= y8[0];
      s1_nyp     <= ny8[0];
    end
  end

  logic [HEIGHT_W-1:0] c00, c10, c01, c11;
  logic [RW:0]         row0, row1;
  logic [RW+8:0]       row0_w, row1_w;
  logic [RAW_W-1:0]    h0, h1;

  assign c00 = rdata[{s1_yp,  s1_xp}];
  assign c10 = rdata[{s1_yp,  s1_nxp}];
  assign c01 = rdata[{s1_nyp, s1_xp}];
  assign c11 = rdata[{s1_nyp, s1_nxp}];

  assign row0 = (RW+1)'(c00) * (RW+1)'(ONE - {1'b0, s1_dx}) + (RW+1)'(c10) * (RW+1)'(s1_dx);
  assign row1 = (RW+1)'(c01) * (RW+1)'(ONE - {1'b0, s1_dx}) + (RW+1)'(c11) * (RW+1)'(s1_dx);

  // bring each row to eight fraction bits
  assign row0_w = ((RW+9)'(row0) << SHL) >> SHR;
  assign row1_w = ((RW+9)'(row1) << SHL) >> SHR;
  assign h0     = row0_w[RAW_W-1:0];
  assign h1     = row1_w[RAW_W-1:0];

  // ---------------- stage 2: blend along y ----------------
  logic             s2_outside;
  logic [FW-1:0]    s2_dy;
  logic [RAW_W-1:0] s2_h0, s2_h1;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_outside <= s1_outside;
      s2_dy      <= s1_dy;
      s2_h0      <= h0;
      s2_h1      <= h1;
    end
  end

  logic [CW:0]      colsum;
  logic [RAW_W-1:0] hval;

  assign colsum = (CW+1)'(s2_h0) * (CW+1)'(ONE - {1'b0, s2_dy})
                + (CW+1)'(s2_h1) * (CW+1)'(s2_dy);
  assign hval   = colsum[FW +: RAW_W];

  // ---------------- stage 3: apply gain ----------------
  logic             s3_outside;
  logic [RAW_W-1:0] s3_h;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_outside <= s2_outside;
      s3_h       <= hval;
    end
  end

  logic [RAW_W+GAIN_W-1:0] gprod;

  assign gprod = (RAW_W+GAIN_W)'(s3_h) * (RAW_W+GAIN_W)'(height_gain);

  // ---------------- stage 4: output register ----------------
  logic             s4_outside;
  logic [RAW_W-1:0] s4_raw, s4_scaled;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_outside <= s3_outside;
      s4_raw     <= s3_outside ? '0 : s3_h;
      s4_scaled  <= s3_outside ? '0 : gprod[GAIN_W +: RAW_W];
    end
  end

  assign rsp.valid         = v4;
  assign rsp.height_raw    = s4_raw;
  assign rsp.height_scaled = s4_scaled;
  assign rsp.outside_map   = s4_outside;

endmodule

### hdl/hbs_checker.sv
// Port-level assertions for the heightmap bilinear sampler, bound to the top level.
module hbs_checker
  import hbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [RAW_W-1:0] height_raw,
  input logic [RAW_W-1:0] height_scaled,
  input logic             outside_map
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(height_raw) &&
                                $stable(height_scaled) && $stable(outside_map))
    else $error("stalled result changed");

  // a point off the map yields zero heights
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && outside_map |-> height_raw == '0 && height_scaled == '0)
    else $error("outside point gave nonzero height");

  // gain stays below one, so the scaled height never exceeds the raw one
  a_scaled_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> height_scaled <= height_raw)
    else $error("scaled height above raw height");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .height_raw    (rsp.height_raw),
  .height_scaled (rsp.height_scaled),
  .outside_map   (rsp.outside_map)
);

### dv/tb.sv
// Self-checking testbench of the heightmap bilinear sampler core.
module tb;
  import hbs_pkg::*;

  localparam int              FRAC     = FRAC_BITS_DEF;
  localparam longint unsigned ONE      = 64'd1 << FRAC;
  localparam int unsigned     INT_TOP  = (1 << (POINT_W - FRAC)) - 1;
  localparam int              WD_LIMIT = 2000;
  localparam int              PHASE_ITEMS = 75;

  typedef struct {
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] scaled;
    logic             outside;
  } height_result_t;

  class height_checker;
    logic [HEIGHT_W-1:0] cells [0:STORE_SIDE*STORE_SIDE-1];
    logic [SIZE_W-1:0]   map_size;
    logic [GAIN_W-1:0]   gain;
    height_result_t      due_heights [$];
    int                  errors;

    function new();
      map_size = MAP_SIZE_RST;
      gain     = HEIGHT_GAIN_RST;
      errors   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_MAP_SIZE:    map_size = v[SIZE_W-1:0];
        REG_HEIGHT_GAIN: gain     = v[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned side();
      int unsigned s;
      int unsigned top;
      s   = map_size;
      top = (MAP_SIZE < STORE_SIDE) ? MAP_SIZE : STORE_SIDE;
      if (s < 2) s = 2;
      if (s > top) s = top;
      return s;
    endfunction

    function logic [63:0] cell_at(int unsigned x, int unsigned y);
      return 64'(cells[(y % STORE_SIDE) * STORE_SIDE + (x % STORE_SIDE)]);
    endfunction

    function logic [63:0] to_q8(logic [63:0] v);
      if (FRAC >= 8) return v >> (FRAC - 8);
      return v << (8 - FRAC);
    endfunction

    function height_result_t interp_height(logic [POINT_W-1:0] px, logic [POINT_W-1:0] py);
      height_result_t r;
      int unsigned    n, xi, yi, nx, ny;
      logic [63:0]    dx, dy, h0, h1, h;
      n  = side();
      xi = px >> FRAC;
      yi = py >> FRAC;
      dx = 64'(px) & (ONE - 1);
      dy = 64'(py) & (ONE - 1);
      if (xi >= n || yi >= n) begin
        r.raw     = '0;
        r.scaled  = '0;
        r.outside = 1'b1;
        return r;
      end
      // clamp the far neighbor to the edge cell
      nx = (xi + 1 < n) ? xi + 1 : n - 1;
      ny = (yi + 1 < n) ? yi + 1 : n - 1;
      h0 = to_q8(cell_at(xi, yi) * (ONE - dx) + cell_at(nx, yi) * dx);
      h1 = to_q8(cell_at(xi, ny) * (ONE - dx) + cell_at(nx, ny) * dx);
      h  = ((h0 * (ONE - dy) + h1 * dy) >> FRAC) & 64'hFF_FFFF;
      r.raw     = h[RAW_W-1:0];
      r.scaled  = RAW_W'((h * 64'(gain)) >> 24);
      r.outside = 1'b0;
      return r;
    endfunction

    function void note_item(cmd_t c, logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                            logic [HEIGHT_W-1:0] ch, logic [POINT_W-1:0] px,
                            logic [POINT_W-1:0] py);
      if (c == CMD_WRITE) cells[int'(cy) * STORE_SIDE + int'(cx)] = ch;
      else due_heights.push_back(interp_height(px, py));
    endfunction

    function void check_result(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] scaled,
                               logic outside);
      height_result_t e;
      if (due_heights.size() == 0) begin
        $error("result with no sample waiting: raw %0h scaled %0h outside %0b",
               raw, scaled, outside);
        errors++;
        return;
      end
      e = due_heights.pop_front();
      if (raw !== e.raw) begin
        $error("height_raw: expected %0h, actual %0h", e.raw, raw);
        errors++;
      end
      if (scaled !== e.scaled) begin
        $error("height_scaled: expected %0h, actual %0h", e.scaled, scaled);
        errors++;
      end
      if (outside !== e.outside) begin
        $error("outside_map: expected %0b, actual %0b", e.outside, outside);
        errors++;
      end
    endfunction

    function int pending();
      return due_heights.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  hbs_req_if req_ch ();
  hbs_rsp_if rsp_ch ();

  heightmap_bilinear_sampler_core #(.FRAC_BITS(FRAC)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  height_checker sb = new();
  bit            cell_written [0:STORE_SIDE*STORE_SIDE-1];
  bit            no_idle = 1'b0;
  int unsigned   issued  = 0;
  int            quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] make_point(int unsigned xi);
    longint unsigned fr;
    case ($urandom_range(0, 7))
      0:       fr = 0;
      1:       fr = ONE - 1;
      default: fr = longint'($urandom) & (ONE - 1);
    endcase
    return POINT_W'((longint'(xi) << FRAC) | fr);
  endfunction

  function automatic int unsigned pick_coord(int unsigned n);
    case ($urandom_range(0, 9))
      0: return n - 1;
      1: return 0;
      2: return (n <= INT_TOP) ? $urandom_range(n, INT_TOP) : $urandom_range(0, n - 1);
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic issue_cmd(cmd_t c, logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                           logic [HEIGHT_W-1:0] ch, logic [POINT_W-1:0] px,
                           logic [POINT_W-1:0] py);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.cell_x      <= cx;
    req_ch.cell_y      <= cy;
    req_ch.cell_height <= ch;
    req_ch.point_x     <= px;
    req_ch.point_y     <= py;
    do @(posedge clk); while (!req_ch.ready);
    issued++;
  endtask

  task automatic write_cell(int unsigned x, int unsigned y, logic [HEIGHT_W-1:0] h);
    cell_written[y * STORE_SIDE + x] = 1'b1;
    issue_cmd(CMD_WRITE, CELL_W'(x), CELL_W'(y), h, POINT_W'($urandom), POINT_W'($urandom));
  endtask

  task automatic fill_cell(int unsigned x, int unsigned y);
    if (!cell_written[y * STORE_SIDE + x]) write_cell(x, y, pick_height());
  endtask

  // Write any neighbor not yet stored, then sample.
  task automatic sample_at(logic [POINT_W-1:0] px, logic [POINT_W-1:0] py);
    int unsigned n, xi, yi, nx, ny;
    n  = sb.side();
    xi = px >> FRAC;
    yi = py >> FRAC;
    if (xi < n && yi < n) begin
      nx = (xi + 1 < n) ? xi + 1 : n - 1;
      ny = (yi + 1 < n) ? yi + 1 : n - 1;
      fill_cell(xi, yi);
      fill_cell(nx, yi);
      fill_cell(xi, ny);
      fill_cell(nx, ny);
    end
    issue_cmd(CMD_SAMPLE, CELL_W'($urandom), CELL_W'($urandom), HEIGHT_W'($urandom), px, py);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
    // let the bus go idle before the next transfer
    @(posedge clk);
  endtask

  // Let the pipeline empty before touching the registers.
  task automatic configure(logic [DATA_W-1:0] size, logic [DATA_W-1:0] g);
    drain();
    repeat (8) @(posedge clk);
    apb_write(REG_MAP_SIZE, size);
    apb_write(REG_HEIGHT_GAIN, g);
  endtask

  task automatic random_item();
    int unsigned n, r;
    n = sb.side();
    r = $urandom_range(0, 99);
    if (r < 60) sample_at(make_point(pick_coord(n)), make_point(pick_coord(n)));
    else if (r < 85) write_cell($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_height());
    else write_cell($urandom_range(0, STORE_SIDE - 1), $urandom_range(0, STORE_SIDE - 1),
                    pick_height());
    if ($urandom_range(0, 99) == 0) drain();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_item(cmd_t'(req_ch.cmd), req_ch.cell_x, req_ch.cell_y, req_ch.cell_height,
                     req_ch.point_x, req_ch.point_y);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.height_raw, rsp_ch.height_scaled, rsp_ch.outside_map);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles before taking each item.
  initial begin : rsp_side
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin : main_seq
    int unsigned ph, start;
    logic [DATA_W-1:0] size_v, gain_v;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_WRITE;
    req_ch.cell_x      <= '0;
    req_ch.cell_y      <= '0;
    req_ch.cell_height <= '0;
    req_ch.point_x     <= '0;
    req_ch.point_y     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full map from reset: corners, fraction extremes, last row and column
    write_cell(0, 0, 16'h0000);
    write_cell(1, 0, 16'hFFFF);
    write_cell(0, 1, 16'hFFFF);
    write_cell(1, 1, 16'hFFFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'h00FF, 16'h00FF);
    sample_at(16'h0080, 16'h0040);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'hFF00, 16'h0000);

    // size below the minimum clamps to two; largest gain
    configure(0, 24'hFF_FFFF);
    sample_at(16'h0100, 16'h0100);
    sample_at(16'h01FF, 16'h01FF);
    sample_at(16'h0200, 16'h0000);
    sample_at(16'h0000, 16'h0200);
    sample_at(16'hFFFF, 16'hFFFF);
    write_cell(200, 200, 16'h1234);

    // size above the maximum clamps to the full store; zero gain
    configure(511, 0);
    sample_at(16'hC8FF, 16'hC880);
    sample_at(16'h1234, 16'h4321);

    configure(1, 24'h01_0000);
    sample_at(16'h0180, 16'h0000);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin size_v = 256; gain_v = $urandom_range(0, 24'hFF_FFFF); end
        1: begin size_v = 2;   gain_v = 0; end
        2: begin size_v = 1;   gain_v = 24'hFF_FFFF; end
        3: begin size_v = 511; gain_v = 24'h01_0000; end
        4: begin size_v = $urandom_range(0, 511); gain_v = $urandom_range(0, 24'hFF_FFFF); end
        5: begin size_v = 300; gain_v = $urandom_range(0, 24'h0F_FFFF); end
        6: begin size_v = 3;   gain_v = $urandom_range(0, 24'hFF_FFFF); end
        default: begin
          size_v = $urandom_range(2, 256);
          gain_v = $urandom_range(0, 24'hFF_FFFF);
        end
      endcase
      configure(size_v, gain_v);
      no_idle = (ph == 2);
      start = issued;
      while (issued - start < PHASE_ITEMS) random_item();
    end
    no_idle = 1'b0;

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
